>>> design/pconv_q7_pkg.sv
`default_nettype none

package pconv_q7_pkg;

  localparam int MAX_LEN_DEF = 256;

  // field widths
  localparam int OP_W     = 2;
  localparam int IDX_W    = 8;
  localparam int SMP_W    = 8;
  localparam int LEN_W    = 9;
  localparam int PT_W     = 10;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 9;
  localparam int PROD_W   = 2 * SMP_W;
  // at most 511 products of 16 bits each
  localparam int ACC_W    = PROD_W + 10;

  localparam int Q7_MAX   = 127;
  localparam int Q7_MIN   = -128;
  localparam int Q7_SHIFT = 7;

  // item opcodes
  localparam logic [OP_W-1:0] OP_WR_A    = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_B    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_LEN_A       = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LEN_B       = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FIRST_POINT = 2'd2;
  localparam logic [CFG_AW-1:0] REG_POINT_COUNT = 2'd3;

  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> design/pconv_q7_ram.sv
`default_nettype none

module pconv_q7_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/pconv_q7_mac.sv
`default_nettype none

module pconv_q7_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pconv_q7_pkg::mac_ctl_t                ctl,
  input  logic [pconv_q7_pkg::SMP_W-1:0]        a_raw,
  input  logic [pconv_q7_pkg::SMP_W-1:0]        b_raw,
  output logic                                  done,
  output logic signed [pconv_q7_pkg::SMP_W-1:0] sat
);

  localparam int ACC_W = pconv_q7_pkg::ACC_W;
  localparam logic signed [ACC_W-1:0] HI = ACC_W'(pconv_q7_pkg::Q7_MAX);
  localparam logic signed [ACC_W-1:0] LO = ACC_W'(pconv_q7_pkg::Q7_MIN);

  logic                                       s1_valid;
  logic                                       s1_last;
  logic                                       s2_valid;
  logic                                       s2_last;
  logic signed [pconv_q7_pkg::PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]                    acc;
  logic signed [ACC_W-1:0]                    sh;

  // s1 lines up with the memory read data, s2 with the product
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      s2_valid <= 1'b0;
      s2_last  <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= ctl.valid;
      s1_last  <= ctl.last;
      s2_valid <= s1_valid;
      s2_last  <= s1_last;
      done     <= s2_valid && s2_last && !ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_raw) * $signed(b_raw);
    if (ctl.clear) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // arithmetic shift floors, then clamp to q7
  always_comb begin
    sh = acc >>> pconv_q7_pkg::Q7_SHIFT;
    if (sh > HI) begin
      sat = HI[pconv_q7_pkg::SMP_W-1:0];
    end else if (sh < LO) begin
      sat = LO[pconv_q7_pkg::SMP_W-1:0];
    end else begin
      sat = sh[pconv_q7_pkg::SMP_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> design/partial_convolution_q7_core.sv
// Partial linear convolution of two q7 sequences, saturated to q7.
// Input channel (in_valid/in_ready, op, index, sample): op write A or write B
// stores a sample at index into its memory and leaves the input ready; op compute
// produces the next output point of the run set by first_point/point_count.
// Output channel (out_valid/out_ready, value, last, range_error): one beat
// per compute item, none for writes or when point_count is zero.
// A compute item goes through prep and init, then reads its taps, where taps is
// the number of overlapping samples for that point, at most min(len_a, len_b).
// One tap is read per cycle from the single read port of each sample memory,
// then multiplied and accumulated in a three-stage pipeline; after the drain the
// result is loaded and the input reopens. A range error goes from prep straight
// to loading its result. Items are handled one at a time; writes are accepted
// only while no compute is running.
// The result sits in an output register: the next item is accepted while it
// waits, but a following compute holds before loading its result until the
// receiver takes the earlier beat.
// Configuration uses cfg_we/cfg_addr/cfg_wdata and must only change while
// the block is idle. Reset sets len_a and len_b to 1, first_point and
// point_count to 0 and the run position to 0; memories hold garbage until written.
`default_nettype none

module partial_convolution_q7_core #(
  parameter int MAX_LEN = pconv_q7_pkg::MAX_LEN_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [pconv_q7_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [pconv_q7_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [pconv_q7_pkg::OP_W-1:0]           op,
  input  logic [pconv_q7_pkg::IDX_W-1:0]          index,
  input  logic signed [pconv_q7_pkg::SMP_W-1:0]   sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pconv_q7_pkg::SMP_W-1:0]   value,
  output logic                                    last,
  output logic                                    range_error
);

  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LCAP  = (MAX_LEN > 511) ? 511 : MAX_LEN;
  localparam int LEN_W = pconv_q7_pkg::LEN_W;
  localparam int PT_W  = pconv_q7_pkg::PT_W;
  localparam int SMP_W = pconv_q7_pkg::SMP_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_INIT  = 6'b000100,
    ST_RUN   = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                 state;
  state_t                 state_next;

  logic [LEN_W-1:0]       len_a;
  logic [LEN_W-1:0]       len_b;
  logic [LEN_W-1:0]       first_point;
  logic [LEN_W-1:0]       point_count;
  logic [LEN_W-1:0]       point_offset;

  logic [LEN_W-1:0]       la;
  logic [LEN_W-1:0]       lb;
  logic [PT_W-1:0]        full;
  logic [PT_W-1:0]        req_end;
  logic [LEN_W-1:0]       off_eff;
  logic                   pt_last;

  logic                   err;
  logic                   last_pt;
  logic [PT_W-1:0]        n;
  logic [PT_W-1:0]        m;
  logic [PT_W-1:0]        m_hi;
  logic [PT_W-1:0]        n_inc;
  logic [PT_W-1:0]        a_pos;

  logic                   in_fire;
  logic                   idx_ok;
  logic                   out_load;

  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr_a;
  logic [AW-1:0]          raddr_b;
  logic [SMP_W-1:0]       rdata_a;
  logic [SMP_W-1:0]       rdata_b;

  pconv_q7_pkg::mac_ctl_t ctl;
  logic                   mac_done;
  logic signed [SMP_W-1:0] mac_sat;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign idx_ok   = (32'(index) < MAX_LEN);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      len_a       <= LEN_W'(1);
      len_b       <= LEN_W'(1);
      first_point <= '0;
      point_count <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        pconv_q7_pkg::REG_LEN_A:       len_a       <= cfg_wdata;
        pconv_q7_pkg::REG_LEN_B:       len_b       <= cfg_wdata;
        pconv_q7_pkg::REG_FIRST_POINT: first_point <= cfg_wdata;
        pconv_q7_pkg::REG_POINT_COUNT: point_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // lengths above the memory size act as the memory size
  always_comb begin
    la = (len_a > LEN_W'(LCAP)) ? LEN_W'(LCAP) : len_a;
    lb = (len_b > LEN_W'(LCAP)) ? LEN_W'(LCAP) : len_b;
    if (la == '0 || lb == '0) begin
      full = '0;
    end else begin
      full = {1'b0, la} + {1'b0, lb} - PT_W'(1);
    end
    req_end = {1'b0, first_point} + {1'b0, point_count};
    off_eff = (point_offset >= point_count) ? '0 : point_offset;
    pt_last = ({1'b0, off_eff} + PT_W'(1)) >= {1'b0, point_count};
    n_inc   = n + PT_W'(1);
    a_pos   = n - m;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && op == pconv_q7_pkg::OP_COMPUTE && point_count != '0) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP:  state_next = (req_end > full) ? ST_DONE : ST_INIT;
      ST_INIT:  state_next = ST_RUN;
      ST_RUN:   state_next = (m == m_hi) ? ST_DRAIN : ST_RUN;
      ST_DRAIN: state_next = mac_done ? ST_DONE : ST_DRAIN;
      ST_DONE:  state_next = out_load ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      point_offset <= '0;
    end else begin
      state <= state_next;
      if (state == ST_PREP) begin
        if (req_end > full) begin
          point_offset <= '0;
        end else begin
          point_offset <= pt_last ? '0 : off_eff + LEN_W'(1);
        end
      end
    end
  end

  // per-point setup and the tap counter
  always_ff @(posedge clk) begin
    case (state)
      ST_PREP: begin
        err     <= (req_end > full);
        last_pt <= pt_last;
        n       <= {1'b0, first_point} + {1'b0, off_eff};
      end
      ST_INIT: begin
        // taps run from max(0, n-la+1) to min(lb-1, n)
        m    <= (n_inc > {1'b0, la}) ? n_inc - {1'b0, la} : '0;
        m_hi <= (n >= {1'b0, lb}) ? {1'b0, lb} - PT_W'(1) : n;
      end
      ST_RUN: begin
        m <= m + PT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value       <= err ? '0 : mac_sat;
      last        <= !err && last_pt;
      range_error <= err;
    end
  end

  // writes only happen in idle and read data is used only while running: no overlap
  assign waddr   = AW'(index);
  assign raddr_a = AW'(a_pos);
  assign raddr_b = AW'(m);

  always_comb begin
    ctl.clear = (state == ST_INIT);
    ctl.valid = (state == ST_RUN);
    ctl.last  = (state == ST_RUN) && (m == m_hi);
  end

  pconv_q7_ram #(
    .WIDTH(SMP_W),
    .DEPTH(MAX_LEN)
  ) u_ram_a (
    .clk  (clk),
    .we   (in_fire && op == pconv_q7_pkg::OP_WR_A && idx_ok),
    .waddr(waddr),
    .wdata(sample),
    .raddr(raddr_a),
    .rdata(rdata_a)
  );

  pconv_q7_ram #(
    .WIDTH(SMP_W),
    .DEPTH(MAX_LEN)
  ) u_ram_b (
    .clk  (clk),
    .we   (in_fire && op == pconv_q7_pkg::OP_WR_B && idx_ok),
    .waddr(waddr),
    .wdata(sample),
    .raddr(raddr_b),
    .rdata(rdata_b)
  );

  pconv_q7_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .a_raw(rdata_a),
    .b_raw(rdata_b),
    .done (mac_done),
    .sat  (mac_sat)
  );

endmodule

`default_nettype wire

>>> design/pconv_q7_checker.sv
`default_nettype none

module pconv_q7_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [pconv_q7_pkg::OP_W-1:0]         op,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [pconv_q7_pkg::SMP_W-1:0] value,
  input logic                                  last,
  input logic                                  range_error
);

  // an error beat carries a zero value and never ends a run
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> value == '0 && !last)
    else $error("range error beat with nonzero value or last");

  // a new result only shows up after the block has been busy
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a busy cycle");

  // nothing comes out right after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(last)
      && $stable(range_error))
    else $error("stalled output beat changed");

  // writes and unused opcodes leave the block ready for the next beat
  a_write_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op != pconv_q7_pkg::OP_COMPUTE |=> in_ready)
    else $error("input stalled after a non-compute beat");

endmodule

bind partial_convolution_q7_core pconv_q7_checker u_pconv_q7_checker (.*);

`default_nettype wire

>>> test/partial_convolution_q7_core_test.sv
`timescale 1ns / 1ps

module partial_convolution_q7_core_test;

  localparam logic [pconv_q7_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SEQ_DEPTH = 256;
  // entries loaded at the low and the high end of both stores
  localparam int LOADED_LOW = 96;
  localparam int LOADED_HIGH = 6;
  // a compute reads at most 256 taps
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_ITEMS = 160;

  typedef struct {
    logic signed [pconv_q7_pkg::SMP_W-1:0] value;
    logic                                  last;
    logic                                  range_error;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [pconv_q7_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [pconv_q7_pkg::CFG_DW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [pconv_q7_pkg::OP_W-1:0] op = '0;
  logic [pconv_q7_pkg::IDX_W-1:0] index = '0;
  logic signed [pconv_q7_pkg::SMP_W-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [pconv_q7_pkg::SMP_W-1:0] value;
  logic last;
  logic range_error;

  // local copy of the block state
  logic signed [pconv_q7_pkg::SMP_W-1:0] seq_a [SEQ_DEPTH];
  logic signed [pconv_q7_pkg::SMP_W-1:0] seq_b [SEQ_DEPTH];
  int cfg_len_a = 1;
  int cfg_len_b = 1;
  int cfg_first = 0;
  int cfg_count = 0;
  int run_pos = 0;

  point_t points_due [$];
  int mismatch_count = 0;
  bit no_gaps = 1'b0;
  bit hold_request = 1'b0;

  partial_convolution_q7_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .index(index),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value(value),
    .last(last),
    .range_error(range_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** partial_convolution_q7_core: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int capped_len(int n);
    return (n > SEQ_DEPTH) ? SEQ_DEPTH : n;
  endfunction

  function automatic int full_len(int la, int lb);
    if (capped_len(la) == 0 || capped_len(lb) == 0) return 0;
    return capped_len(la) + capped_len(lb) - 1;
  endfunction

  // updates the local state for one accepted beat and queues the point a compute returns
  function automatic void step_convolver(logic [pconv_q7_pkg::OP_W-1:0] kind,
                                         logic [pconv_q7_pkg::IDX_W-1:0] pos,
                                         logic [pconv_q7_pkg::SMP_W-1:0] smp);
    int la;
    int lb;
    int n;
    int acc;
    int v;
    point_t p;
    case (kind)
      pconv_q7_pkg::OP_WR_A: seq_a[pos] = smp;
      pconv_q7_pkg::OP_WR_B: seq_b[pos] = smp;
      pconv_q7_pkg::OP_COMPUTE: begin
        if (cfg_count != 0) begin
          la = capped_len(cfg_len_a);
          lb = capped_len(cfg_len_b);
          if (cfg_first + cfg_count > full_len(cfg_len_a, cfg_len_b)) begin
            run_pos = 0;
            p.value = '0;
            p.last = 1'b0;
            p.range_error = 1'b1;
          end else begin
            if (run_pos >= cfg_count) run_pos = 0;
            n = cfg_first + run_pos;
            acc = 0;
            for (int m = 0; m < lb; m++) begin
              if (m <= n && n - m < la) acc += int'(seq_a[n - m]) * int'(seq_b[m]);
            end
            v = acc >>> pconv_q7_pkg::Q7_SHIFT;
            if (v > pconv_q7_pkg::Q7_MAX) v = pconv_q7_pkg::Q7_MAX;
            if (v < pconv_q7_pkg::Q7_MIN) v = pconv_q7_pkg::Q7_MIN;
            p.value = v[pconv_q7_pkg::SMP_W-1:0];
            p.last = (run_pos + 1 >= cfg_count);
            p.range_error = 1'b0;
            run_pos = p.last ? 0 : run_pos + 1;
          end
          points_due.push_back(p);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : check_beat
    point_t want;
    if (!rst && out_valid && out_ready) begin
      if (points_due.size() == 0) begin
        $display("%0t: unexpected beat value %0d last %0b range_error %0b", $time, value,
                 last, range_error);
        mismatch_count++;
      end else begin
        want = points_due.pop_front();
        if (value !== want.value) begin
          $display("%0t: value expected %0d got %0d", $time, want.value, value);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, last);
          mismatch_count++;
        end
        if (range_error !== want.range_error) begin
          $display("%0t: range_error expected %0b got %0b", $time, want.range_error,
                   range_error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : receiver
    int gap;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [pconv_q7_pkg::OP_W-1:0] kind,
                           input logic [pconv_q7_pkg::IDX_W-1:0] pos,
                           input logic [pconv_q7_pkg::SMP_W-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    index <= pos;
    sample <= smp;
    do @(posedge clk); while (!in_ready);
    step_convolver(kind, pos, smp);
  endtask

  task automatic send_compute(input int count);
    repeat (count) send_item(pconv_q7_pkg::OP_COMPUTE, pconv_q7_pkg::IDX_W'($urandom),
                             pconv_q7_pkg::SMP_W'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pconv_q7_pkg::CFG_AW-1:0] addr, input int data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data[pconv_q7_pkg::CFG_DW-1:0];
    @(posedge clk);
    case (addr)
      pconv_q7_pkg::REG_LEN_A: cfg_len_a = data;
      pconv_q7_pkg::REG_LEN_B: cfg_len_b = data;
      pconv_q7_pkg::REG_FIRST_POINT: cfg_first = data;
      pconv_q7_pkg::REG_POINT_COUNT: cfg_count = data;
      default: ;
    endcase
  endtask

  // registers change only once the block has gone quiet
  task automatic set_config(input int la, input int lb, input int fp, input int pc);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(pconv_q7_pkg::REG_LEN_A, la);
    write_reg(pconv_q7_pkg::REG_LEN_B, lb);
    write_reg(pconv_q7_pkg::REG_FIRST_POINT, fp);
    write_reg(pconv_q7_pkg::REG_POINT_COUNT, pc);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    // point count is zero after reset, so nothing comes out
    send_compute(2);
    send_item(OP_UNUSED, 8'hff, 8'h7f);
  endtask

  // points below LOADED_LOW and the last few points read only these entries
  task automatic test_load_sequences();
    for (int i = 0; i < LOADED_LOW; i++) begin
      send_item(pconv_q7_pkg::OP_WR_A, i[pconv_q7_pkg::IDX_W-1:0],
                pconv_q7_pkg::SMP_W'($urandom));
      send_item(pconv_q7_pkg::OP_WR_B, i[pconv_q7_pkg::IDX_W-1:0],
                pconv_q7_pkg::SMP_W'($urandom));
    end
    for (int i = SEQ_DEPTH - LOADED_HIGH; i < SEQ_DEPTH; i++) begin
      send_item(pconv_q7_pkg::OP_WR_A, i[pconv_q7_pkg::IDX_W-1:0],
                pconv_q7_pkg::SMP_W'($urandom));
      send_item(pconv_q7_pkg::OP_WR_B, i[pconv_q7_pkg::IDX_W-1:0],
                pconv_q7_pkg::SMP_W'($urandom));
    end
  endtask

  task automatic test_saturation();
    send_item(pconv_q7_pkg::OP_WR_A, 8'd0, 8'h80);
    send_item(pconv_q7_pkg::OP_WR_A, 8'd1, 8'h7f);
    send_item(pconv_q7_pkg::OP_WR_B, 8'd0, 8'h80);
    send_item(pconv_q7_pkg::OP_WR_B, 8'd1, 8'h80);
    set_config(2, 2, 0, 3);
    send_compute(3);
    // both taps negative drive the middle point below the floor
    send_item(pconv_q7_pkg::OP_WR_A, 8'd0, 8'h7f);
    send_compute(3);
    send_item(pconv_q7_pkg::OP_WR_A, 8'd255, 8'h80);
    send_item(pconv_q7_pkg::OP_WR_B, 8'd255, 8'h80);
    set_config(256, 256, 510, 1);
    send_compute(1);
  endtask

  task automatic test_range_limits();
    set_config(3, 4, 4, 3);
    send_compute(1);
    set_config(3, 4, 0, 3);
    send_compute(2);
    // a range error in mid-run sends the run back to its start
    set_config(3, 4, 4, 3);
    send_compute(1);
    set_config(3, 4, 0, 3);
    send_compute(1);
    set_config(0, 5, 0, 1);
    send_compute(1);
    // lengths above the store size act as the store size
    set_config(300, 511, 505, 6);
    send_compute(2);
    set_config(511, 511, 511, 511);
    send_compute(1);
    set_config(4, 4, 0, 0);
    send_compute(1);
  endtask

  task automatic test_midrun_change();
    set_config(8, 8, 0, 5);
    send_compute(3);
    set_config(8, 8, 0, 2);
    send_compute(2);
    set_config(8, 8, 0, 5);
    send_compute(1);
    set_config(8, 8, 2, 6);
    send_compute(2);
  endtask

  task automatic test_output_stall();
    set_config(16, 16, 0, 8);
    hold_request = 1'b1;
    while (hold_request) @(posedge clk);
    no_gaps = 1'b1;
    send_compute(8);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_drain_pauses();
    set_config(5, 7, 1, 4);
    repeat (3) begin
      send_compute(3);
      send_item(pconv_q7_pkg::OP_WR_B, pconv_q7_pkg::IDX_W'($urandom_range(0, 6)),
                pconv_q7_pkg::SMP_W'($urandom));
      wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    set_config(6, 9, 0, 14);
    no_gaps = 1'b1;
    repeat (30) begin
      if ($urandom_range(0, 3) == 0)
        send_item(pconv_q7_pkg::OP_WR_A, pconv_q7_pkg::IDX_W'($urandom_range(0, 5)),
                  pconv_q7_pkg::SMP_W'($urandom));
      else
        send_compute(1);
    end
    no_gaps = 1'b0;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 12);
    if (r < 92) return $urandom_range(13, 256);
    return $urandom_range(257, 511);
  endfunction

  task automatic test_random_traffic();
    int sent;
    int la;
    int lb;
    int fp;
    int pc;
    int full;
    int lim;
    int r;
    int burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      la = pick_len();
      lb = pick_len();
      r = $urandom_range(0, 99);
      if (r < 88 && r >= 80) begin
        if ($urandom_range(0, 1) == 0) la = 0;
        else lb = 0;
      end
      full = full_len(la, lb);
      // well-formed runs stay on points that read loaded entries only
      lim = (full < LOADED_LOW) ? full : LOADED_LOW;
      if (r < 78 && lim > 0) begin
        // well-formed run inside the full convolution
        pc = $urandom_range(1, (lim < 12) ? lim : (($urandom_range(0, 3) == 0) ? 12 : 6));
        fp = $urandom_range(0, lim - pc);
      end else if (r < 95) begin
        pc = $urandom_range(1, 511);
        fp = $urandom_range(0, 511);
        if (fp + pc <= full) fp = full - pc + 1;
      end else begin
        pc = 0;
        fp = $urandom_range(0, 511);
      end
      set_config(la, lb, fp, pc);
      no_gaps = ($urandom_range(0, 9) == 0);
      burst = $urandom_range(8, 40);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 62) begin
          send_compute(1);
          sent++;
        end else if (r < 79) begin
          send_item(pconv_q7_pkg::OP_WR_A, pconv_q7_pkg::IDX_W'($urandom),
                    pconv_q7_pkg::SMP_W'($urandom));
          sent++;
        end else if (r < 96) begin
          send_item(pconv_q7_pkg::OP_WR_B, pconv_q7_pkg::IDX_W'($urandom),
                    pconv_q7_pkg::SMP_W'($urandom));
          sent++;
        end else begin
          send_item(OP_UNUSED, pconv_q7_pkg::IDX_W'($urandom),
                    pconv_q7_pkg::SMP_W'($urandom));
        end
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_load_sequences();
    test_saturation();
    test_range_limits();
    test_midrun_change();
    test_output_stall();
    test_drain_pauses();
    test_back_to_back();
    test_random_traffic();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** partial_convolution_q7_core: PASSED **");
    end else begin
      $display("** partial_convolution_q7_core: FAILED **");
    end
    $finish;
  end

endmodule
